### src/sdct_pkg.sv
`default_nettype none

package sdct_pkg;

  localparam int NUM_BP = 10;

  localparam logic [31:0] CONFIRM_DELAY_MS = 32'd10;
  localparam logic [13:0] NEUTRAL_RPM      = 14'd2000;
  localparam logic [9:0]  CUT_MIN          = 10'd10;
  localparam logic [9:0]  CUT_MAX          = 10'd1000;
  localparam logic [19:0] CUT_DIV          = 20'd1000000;

  localparam logic [13:0] SPEED_BP [NUM_BP] = '{
    14'd2000, 14'd2500, 14'd3000, 14'd3500, 14'd4000,
    14'd5000, 14'd6000, 14'd8000, 14'd10000, 14'd14000
  };
  localparam logic [6:0] LOAD_BP [NUM_BP] = '{
    7'd0, 7'd5, 7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd60, 7'd80, 7'd100
  };

  // shift events
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_UP      = 2'd1;
  localparam logic [1:0] EV_DOWN    = 2'd2;
  localparam logic [1:0] EV_NEUTRAL = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_CUT_ENABLE    = 3'd0;
  localparam logic [2:0] REG_BASE_CUT_MS   = 3'd1;
  localparam logic [2:0] REG_FORCE_THR     = 3'd2;
  localparam logic [2:0] REG_SPEED_GAIN_LO = 3'd3;
  localparam logic [2:0] REG_SPEED_GAIN_HI = 3'd4;
  localparam logic [2:0] REG_LOAD_GAIN_LO  = 3'd5;
  localparam logic [2:0] REG_LOAD_GAIN_HI  = 3'd6;
  localparam logic [2:0] REG_GEAR_GAIN     = 3'd7;

  typedef struct packed {
    logic        start;
    logic [7:0]  base;
    logic [7:0]  gear_pct;
    logic [13:0] rpm;
    logic [6:0]  load;
  } cut_req_t;

  typedef struct packed {
    logic       done;
    logic [9:0] cut_ms;
  } cut_rsp_t;

  // first span [bp[i], bp[i+1]] holding x: count breakpoints 1..8 below x
  function automatic logic [3:0] speed_seg(logic [13:0] x);
    logic [3:0] seg;
    seg = 4'd0;
    for (int j = 1; j < NUM_BP - 1; j++) begin
      if (SPEED_BP[j] < x) seg = seg + 4'd1;
    end
    return seg;
  endfunction

  function automatic logic [3:0] load_seg(logic [6:0] x);
    logic [3:0] seg;
    seg = 4'd0;
    for (int j = 1; j < NUM_BP - 1; j++) begin
      if (LOAD_BP[j] < x) seg = seg + 4'd1;
    end
    return seg;
  endfunction

  function automatic logic [7:0] gain_byte(logic [79:0] tab, logic [3:0] k);
    return tab[{k, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

### src/sdct_cut.sv
`default_nettype none

module sdct_cut (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sdct_pkg::cut_req_t req_i,
  input  logic [79:0]        spd_gain_i,
  input  logic [79:0]        ld_gain_i,
  output sdct_pkg::cut_rsp_t rsp_o
);
  import sdct_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_NUM  = 3'd1;
  localparam logic [2:0] ST_DIVG = 3'd2;
  localparam logic [2:0] ST_MULS = 3'd3;
  localparam logic [2:0] ST_MULL = 3'd4;
  localparam logic [2:0] ST_DIVT = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  localparam logic [3:0] NUM_LAST  = 4'd7;
  localparam logic [3:0] DIVG_LAST = 4'd15;
  localparam logic [3:0] MUL_LAST  = 4'd15;
  localparam logic [3:0] DIVT_LAST = 4'd12;

  localparam logic [6:0] LOAD_TOP = LOAD_BP[NUM_BP-1];

  logic [2:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;

  // interpolation numerators
  logic [7:0]  sga_q, sgb_q, lga_q, lgb_q;
  logic [19:0] sbx_q, sxa_q, snum_q;
  logic [12:0] lbx_q, lxa_q, lnum_q;
  logic [11:0] sdiv_q;
  logic [4:0]  ldiv_q;
  // gain dividers
  logic [11:0] srem_q;
  logic [4:0]  lrem_q;
  logic [15:0] sden_q, squo_q, lden_q, lquo_q;
  // shared shift-add multiplier
  logic [47:0] acc_q, mcand_q;
  logic [7:0]  mplr_q;
  // final divide by 10^6
  logic [19:0] trem_q;
  logic [12:0] tden_q, tquo_q;

  logic [6:0]  lx;
  logic [3:0]  sseg, sseg1, lseg, lseg1;
  logic [13:0] sa, sb;
  logic [6:0]  la, lb;

  logic [19:0] snum_step;
  logic [12:0] lnum_step;
  logic        mul_bit;
  logic [47:0] acc_step;
  logic [12:0] scand, sdiff;
  logic        sge;
  logic [11:0] srem_step;
  logic [5:0]  lcand, ldiff;
  logic        lge;
  logic [4:0]  lrem_step;
  logic [20:0] tcand, tdiff;
  logic        tge;
  logic [19:0] trem_step;
  logic [9:0]  cut;

  assign lx    = (req_i.load > LOAD_TOP) ? LOAD_TOP : req_i.load;
  assign sseg  = speed_seg(req_i.rpm);
  assign sseg1 = sseg + 4'd1;
  assign lseg  = load_seg(lx);
  assign lseg1 = lseg + 4'd1;
  assign sa    = SPEED_BP[sseg];
  assign sb    = SPEED_BP[sseg1];
  assign la    = LOAD_BP[lseg];
  assign lb    = LOAD_BP[lseg1];

  assign snum_step = snum_q + (sga_q[0] ? sbx_q : 20'd0) + (sgb_q[0] ? sxa_q : 20'd0);
  assign lnum_step = lnum_q + (lga_q[0] ? lbx_q : 13'd0) + (lgb_q[0] ? lxa_q : 13'd0);

  always_comb begin
    unique case (state_q)
      ST_NUM:  mul_bit = mplr_q[0];
      ST_MULS: mul_bit = squo_q[0];
      ST_MULL: mul_bit = lquo_q[0];
      default: mul_bit = 1'b0;
    endcase
  end

  assign acc_step = acc_q + (mul_bit ? mcand_q : 48'd0);

  // restoring division, one quotient bit per cycle
  assign scand     = {srem_q, sden_q[15]};
  assign sdiff     = scand - {1'b0, sdiv_q};
  assign sge       = scand >= {1'b0, sdiv_q};
  assign srem_step = sge ? sdiff[11:0] : scand[11:0];

  assign lcand     = {lrem_q, lden_q[15]};
  assign ldiff     = lcand - {1'b0, ldiv_q};
  assign lge       = lcand >= {1'b0, ldiv_q};
  assign lrem_step = lge ? ldiff[4:0] : lcand[4:0];

  assign tcand     = {trem_q, tden_q[12]};
  assign tdiff     = tcand - {1'b0, CUT_DIV};
  assign tge       = tcand >= {1'b0, CUT_DIV};
  assign trem_step = tge ? tdiff[19:0] : tcand[19:0];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + 4'd1;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (req_i.start) state_d = ST_NUM;
      end
      ST_NUM: begin
        if (cnt_q == NUM_LAST) begin
          state_d = ST_DIVG;
          cnt_d   = '0;
        end
      end
      ST_DIVG: begin
        if (cnt_q == DIVG_LAST) begin
          state_d = ST_MULS;
          cnt_d   = '0;
        end
      end
      ST_MULS: begin
        if (cnt_q == MUL_LAST) begin
          state_d = ST_MULL;
          cnt_d   = '0;
        end
      end
      ST_MULL: begin
        if (cnt_q == MUL_LAST) begin
          state_d = ST_DIVT;
          cnt_d   = '0;
        end
      end
      ST_DIVT: begin
        if (cnt_q == DIVT_LAST) begin
          state_d = ST_DONE;
          cnt_d   = '0;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.start) begin
          sga_q   <= gain_byte(spd_gain_i, sseg);
          sgb_q   <= gain_byte(spd_gain_i, sseg1);
          lga_q   <= gain_byte(ld_gain_i, lseg);
          lgb_q   <= gain_byte(ld_gain_i, lseg1);
          sbx_q   <= {6'd0, sb - req_i.rpm};
          sxa_q   <= {6'd0, req_i.rpm - sa};
          lbx_q   <= {6'd0, lb - lx};
          lxa_q   <= {6'd0, lx - la};
          sdiv_q  <= 12'(sb - sa);
          ldiv_q  <= 5'(lb - la);
          snum_q  <= '0;
          lnum_q  <= '0;
          acc_q   <= '0;
          mcand_q <= {40'd0, req_i.base};
          mplr_q  <= req_i.gear_pct;
        end
      end
      ST_NUM: begin
        // both numerators and base * gear gain, one gain bit per cycle
        snum_q  <= snum_step;
        lnum_q  <= lnum_step;
        sga_q   <= sga_q >> 1;
        sgb_q   <= sgb_q >> 1;
        lga_q   <= lga_q >> 1;
        lgb_q   <= lgb_q >> 1;
        sbx_q   <= sbx_q << 1;
        sxa_q   <= sxa_q << 1;
        lbx_q   <= lbx_q << 1;
        lxa_q   <= lxa_q << 1;
        acc_q   <= acc_step;
        mcand_q <= mcand_q << 1;
        mplr_q  <= mplr_q >> 1;
        if (cnt_q == NUM_LAST) begin
          // dividend is num * 256: the upper bits seed the remainder
          srem_q <= snum_step[19:8];
          sden_q <= {snum_step[7:0], 8'h00};
          lrem_q <= lnum_step[12:8];
          lden_q <= {lnum_step[7:0], 8'h00};
        end
      end
      ST_DIVG: begin
        srem_q <= srem_step;
        sden_q <= sden_q << 1;
        squo_q <= {squo_q[14:0], sge};
        lrem_q <= lrem_step;
        lden_q <= lden_q << 1;
        lquo_q <= {lquo_q[14:0], lge};
        if (cnt_q == DIVG_LAST) begin
          mcand_q <= acc_q;
          acc_q   <= '0;
        end
      end
      ST_MULS: begin
        mcand_q <= mcand_q << 1;
        squo_q  <= squo_q >> 1;
        acc_q   <= acc_step;
        if (cnt_q == MUL_LAST) begin
          mcand_q <= acc_step;
          acc_q   <= '0;
        end
      end
      ST_MULL: begin
        mcand_q <= mcand_q << 1;
        lquo_q  <= lquo_q >> 1;
        acc_q   <= acc_step;
        if (cnt_q == MUL_LAST) begin
          // drop the Q.8 * Q.8 fraction, then divide by 10^6
          trem_q <= {1'b0, acc_step[47:29]};
          tden_q <= acc_step[28:16];
        end
      end
      ST_DIVT: begin
        trem_q <= trem_step;
        tden_q <= tden_q << 1;
        tquo_q <= {tquo_q[11:0], tge};
      end
      default: ;
    endcase
  end

  always_comb begin
    if (tquo_q == '0) begin
      cut = '0;
    end else if (tquo_q < 13'(CUT_MIN)) begin
      cut = CUT_MIN;
    end else if (tquo_q > 13'(CUT_MAX)) begin
      cut = CUT_MAX;
    end else begin
      cut = tquo_q[9:0];
    end
  end

  assign rsp_o.done   = (state_q == ST_DONE);
  assign rsp_o.cut_ms = cut;

endmodule

`default_nettype wire

### src/shift_detect_cut_time_unit.sv
// Lever shift detector with ignition cut time.
//
// Input stream (s_axis): one item per lever sample with force, engine speed,
// load and a millisecond time. Output stream (m_axis): one item per sample
// with the gear after the sample, the shift event and the cut time.
// Configuration channel (cfg_*): index 0..7 selects the register, always
// ready; write only while no sample is in flight.
//
// A sample without an upshift cut passes through the ST_OUT state into
// the output register. An upshift that needs a cut time runs the
// bit-serial arithmetic unit: the interpolation products, the gain
// divides, the speed and load gain products and the final divide, and
// the result then goes to the output register. One sample is in work at
// a time; the next is taken once the result sits in the output register.
// Reset clears gear (neutral), detector state and deadline and loads the
// default register values. When the receiver stalls, the output item holds
// and a finished next result waits until the output register frees.

`default_nettype none

module shift_detect_cut_time_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // force_req[8:0], engine_rpm[22:9], load_pct[29:23], now_ms[61:30]
  input  logic [63:0] s_axis_tdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // gear[2:0], event_res[4:3], cut_ms[14:5]
  output logic [15:0] m_axis_tdata_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import sdct_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CUT  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0] state_q, state_d;

  // configuration
  logic        cut_en_q;
  logic [7:0]  base_q;
  logic [15:0] thr_q;
  logic [63:0] sg_lo_q, lg_lo_q;
  logic [15:0] sg_hi_q, lg_hi_q;
  logic [39:0] gg_q;

  // detector state
  logic [2:0]  gear_q, gear_d;
  logic        armed_q, armed_d, fired_q, fired_d, npend_q, npend_d;
  logic [31:0] dline_q, dline_d;

  // pending result and output register
  logic [2:0]  res_gear_q;
  logic [1:0]  res_ev_q;
  logic [9:0]  res_cut_q;
  logic        m_valid_q;
  logic [15:0] m_data_q;

  logic        s_acc, out_load;
  logic [8:0]  fbits, mag;
  logic [13:0] rpm;
  logic [6:0]  load;
  logic [31:0] now, since;
  logic        down, rel, arm_hit, full_hit, after, rpm_ok;
  logic [7:0]  thr, gpct;
  logic [10:0] mag5, thr2, thr3;
  logic [1:0]  ev;
  logic [2:0]  gidx;
  logic        need_cut;

  cut_req_t cut_req;
  cut_rsp_t cut_rsp;

  assign fbits = s_axis_tdata_i[8:0];
  assign rpm   = s_axis_tdata_i[22:9];
  assign load  = s_axis_tdata_i[29:23];
  assign now   = s_axis_tdata_i[61:30];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  assign down     = fbits[8];
  assign mag      = down ? (9'd0 - fbits) : fbits;
  assign thr      = down ? thr_q[15:8] : thr_q[7:0];
  assign mag5     = {mag, 2'b00} + {2'b00, mag};
  assign thr2     = {2'b00, thr, 1'b0};
  assign thr3     = {3'b000, thr} + {2'b00, thr, 1'b0};
  assign rel      = mag5 <= thr2;
  assign arm_hit  = mag5 >= thr3;
  assign full_hit = mag >= {1'b0, thr};
  assign since    = now - dline_q - 32'd1;
  assign after    = since < 32'h7FFF_FFFF;
  assign rpm_ok   = (rpm >= SPEED_BP[0]) && (rpm <= SPEED_BP[NUM_BP-1]);

  always_comb begin
    gear_d   = gear_q;
    armed_d  = armed_q;
    fired_d  = fired_q;
    npend_d  = npend_q;
    dline_d  = dline_q;
    ev       = EV_NONE;
    gidx     = 3'd0;
    need_cut = 1'b0;
    if (rel) begin
      armed_d = 1'b0;
      fired_d = 1'b0;
    end
    if (!fired_d) begin
      if (!armed_d) begin
        if (arm_hit) begin
          if (!down && gear_q == 3'd1 && rpm < NEUTRAL_RPM) npend_d = 1'b1;
          armed_d = 1'b1;
          dline_d = now + CONFIRM_DELAY_MS;
        end
      end else if (full_hit && after) begin
        fired_d = 1'b1;
        if (down) begin
          gear_d = (gear_q > 3'd1) ? gear_q - 3'd1 : 3'd1;
          ev     = EV_DOWN;
        end else begin
          gidx   = (gear_q < 3'd5) ? gear_q : 3'd5;
          gear_d = (gear_q < 3'd6) ? gear_q + 3'd1 : 3'd6;
          if (npend_q) begin
            gear_d  = 3'd0;
            npend_d = 1'b0;
            ev      = EV_NEUTRAL;
          end else begin
            ev = EV_UP;
            // from neutral go straight to second, with the first-gear gain
            if (gidx == 3'd0) begin
              gear_d = 3'd2;
              gidx   = 3'd1;
            end
            need_cut = cut_en_q && rpm_ok;
          end
        end
      end
    end
  end

  always_comb begin
    unique case (gidx)
      3'd1:    gpct = gg_q[7:0];
      3'd2:    gpct = gg_q[15:8];
      3'd3:    gpct = gg_q[23:16];
      3'd4:    gpct = gg_q[31:24];
      3'd5:    gpct = gg_q[39:32];
      default: gpct = 8'd0;
    endcase
  end

  assign cut_req.start    = s_acc && need_cut;
  assign cut_req.base     = base_q;
  assign cut_req.gear_pct = gpct;
  assign cut_req.rpm      = rpm;
  assign cut_req.load     = load;

  sdct_cut u_cut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (cut_req),
    .spd_gain_i ({sg_hi_q, sg_lo_q}),
    .ld_gain_i  ({lg_hi_q, lg_lo_q}),
    .rsp_o      (cut_rsp)
  );

  assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) state_d = need_cut ? ST_CUT : ST_OUT;
      end
      ST_CUT: begin
        if (cut_rsp.done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      gear_q    <= 3'd0;
      armed_q   <= 1'b0;
      fired_q   <= 1'b0;
      npend_q   <= 1'b0;
      dline_q   <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (s_acc) begin
        gear_q  <= gear_d;
        armed_q <= armed_d;
        fired_q <= fired_d;
        npend_q <= npend_d;
        dline_q <= dline_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_en_q <= 1'b1;
      base_q   <= 8'd80;
      thr_q    <= 16'h6464;
      sg_lo_q  <= 64'h6464_6464_6464_6464;
      sg_hi_q  <= 16'h6464;
      lg_lo_q  <= 64'h6464_6464_6464_6464;
      lg_hi_q  <= 16'h6464;
      gg_q     <= 40'h64_6464_6E78;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_CUT_ENABLE:    cut_en_q <= cfg_data_i[0];
        REG_BASE_CUT_MS:   base_q   <= cfg_data_i[7:0];
        REG_FORCE_THR:     thr_q    <= cfg_data_i[15:0];
        REG_SPEED_GAIN_LO: sg_lo_q  <= cfg_data_i;
        REG_SPEED_GAIN_HI: sg_hi_q  <= cfg_data_i[15:0];
        REG_LOAD_GAIN_LO:  lg_lo_q  <= cfg_data_i;
        REG_LOAD_GAIN_HI:  lg_hi_q  <= cfg_data_i[15:0];
        REG_GEAR_GAIN:     gg_q     <= cfg_data_i[39:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      res_gear_q <= gear_d;
      res_ev_q   <= ev;
      res_cut_q  <= '0;
    end
    if (state_q == ST_CUT && cut_rsp.done) begin
      res_cut_q <= cut_rsp.cut_ms;
    end
    if (out_load) begin
      m_data_q <= {1'b0, res_cut_q, res_ev_q, res_gear_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

`default_nettype wire

### src/sdct_checker.sv
`default_nettype none

module sdct_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [15:0] m_axis_tdata_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i
);
  import sdct_pkg::*;

  logic [1:0] ev;
  logic [9:0] cut;

  assign ev  = m_axis_tdata_o[4:3];
  assign cut = m_axis_tdata_o[14:5];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output item changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second item taken while one is in work");

  a_cut_only_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && ev != EV_UP |-> cut == 10'd0)
    else $error("cut time on an item that is no upshift");

  a_cut_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && cut != 10'd0 |-> cut >= CUT_MIN && cut <= CUT_MAX
      && m_axis_tdata_o[2:0] <= 3'd6)
    else $error("cut time or gear out of range");

endmodule

bind shift_detect_cut_time_unit sdct_checker u_sdct_checker (.*);

`default_nettype wire

### bench/tb_shift_detect_cut_time_unit.sv
`timescale 1ns / 100ps

module tb_shift_detect_cut_time_unit;
  import sdct_pkg::*;

  localparam int unsigned RPM_PTS [10] = '{2000, 2500, 3000, 3500, 4000,
                                           5000, 6000, 8000, 10000, 14000};
  localparam int unsigned LOAD_PTS [10] = '{0, 5, 10, 20, 30, 40, 50, 60, 80, 100};
  localparam logic [31:0] HOLD_MS       = 32'd10;
  localparam int unsigned NEUTRAL_BELOW = 2000;
  localparam int unsigned SHORTEST_CUT  = 10;
  localparam int unsigned LONGEST_CUT   = 1000;
  localparam int          STALL_LIMIT   = 4000;
  localparam int          RANDOM_ITEMS  = 1100;
  localparam int          NUM_PHASES    = 8;
  localparam logic [2:0]  REG_LIST [8]  = '{REG_CUT_ENABLE, REG_BASE_CUT_MS, REG_FORCE_THR,
                                            REG_SPEED_GAIN_LO, REG_SPEED_GAIN_HI,
                                            REG_LOAD_GAIN_LO, REG_LOAD_GAIN_HI, REG_GEAR_GAIN};

  typedef enum {CFG_RANDOM, CFG_MAX, CFG_MIN, CFG_LOW} cfg_kind_e;

  typedef struct packed {
    logic [2:0] gear;
    logic [1:0] ev;
    logic [9:0] cut;
  } shift_result_t;

  class shift_scoreboard;
    logic        cut_en;
    logic [7:0]  base_ms;
    logic [15:0] thr_pair;
    logic [79:0] speed_tab;
    logic [79:0] load_tab;
    logic [39:0] gear_tab;
    logic [2:0]  gear;
    logic        armed;
    logic        fired;
    logic        neutral_pend;
    logic [31:0] deadline;
    shift_result_t expected_q[$];
    int          fails;

    function new();
      cut_en       = 1'b1;
      base_ms      = 8'd80;
      thr_pair     = 16'h6464;
      speed_tab    = {16'h6464, 64'h6464_6464_6464_6464};
      load_tab     = {16'h6464, 64'h6464_6464_6464_6464};
      gear_tab     = 40'h64_6464_6E78;
      gear         = 3'd0;
      armed        = 1'b0;
      fired        = 1'b0;
      neutral_pend = 1'b0;
      deadline     = 32'd0;
      fails        = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        REG_CUT_ENABLE:    cut_en = val[0];
        REG_BASE_CUT_MS:   base_ms = val[7:0];
        REG_FORCE_THR:     thr_pair = val[15:0];
        REG_SPEED_GAIN_LO: speed_tab[63:0] = val;
        REG_SPEED_GAIN_HI: speed_tab[79:64] = val[15:0];
        REG_LOAD_GAIN_LO:  load_tab[63:0] = val;
        REG_LOAD_GAIN_HI:  load_tab[79:64] = val[15:0];
        REG_GEAR_GAIN:     gear_tab = val[39:0];
        default: ;
      endcase
    endfunction

    function int unsigned pt(bit by_load, int unsigned k);
      return by_load ? LOAD_PTS[k] : RPM_PTS[k];
    endfunction

    // Q.8 percent gain, linear between the first pair of breakpoints around x
    function logic [63:0] gain_q8(logic [79:0] tab, bit by_load, int unsigned x);
      int unsigned i;
      int unsigned a;
      int unsigned b;
      logic [63:0] ga;
      logic [63:0] gb;
      logic [63:0] num;
      i = 0;
      while (i < 8 && !(x >= pt(by_load, i) && x <= pt(by_load, i + 1))) i++;
      a   = pt(by_load, i);
      b   = pt(by_load, i + 1);
      ga  = 64'(tab[8*i +: 8]);
      gb  = 64'(tab[8*(i+1) +: 8]);
      num = ga * 64'(b - x) + gb * 64'(x - a);
      return (num * 64'd256) / 64'(b - a);
    endfunction

    function logic [9:0] cut_time(int unsigned rpm, int unsigned ld, int unsigned gidx);
      logic [63:0] gs;
      logic [63:0] gl;
      logic [63:0] gg;
      logic [63:0] t;
      gs = gain_q8(speed_tab, 1'b0, rpm);
      gl = gain_q8(load_tab, 1'b1, (ld > 100) ? 100 : ld);
      gg = 64'(gear_tab[8*(gidx-1) +: 8]);
      t  = (64'(base_ms) * gs * gl * gg) / 64'd65_536_000_000;
      if (!cut_en) t = 64'd0;
      if (t != 64'd0) begin
        if (t < SHORTEST_CUT) t = SHORTEST_CUT;
        if (t > LONGEST_CUT) t = LONGEST_CUT;
      end
      return t[9:0];
    endfunction

    function bit past_deadline(logic [31:0] now);
      logic [31:0] d;
      d = now - deadline - 32'd1;
      return d < 32'h7FFF_FFFF;
    endfunction

    function void note_sample(logic [63:0] item);
      logic [8:0]    f;
      int unsigned   rpm;
      int unsigned   ld;
      logic [31:0]   now;
      bit            dn;
      int unsigned   mag;
      int unsigned   thr;
      int unsigned   gidx;
      shift_result_t res;
      f   = item[8:0];
      rpm = item[22:9];
      ld  = item[29:23];
      now = item[61:30];
      dn  = f[8];
      mag = dn ? (32'h200 - 32'(f)) : 32'(f);
      thr = dn ? thr_pair[15:8] : thr_pair[7:0];
      res.ev  = EV_NONE;
      res.cut = 10'd0;
      if (mag * 5 <= thr * 2) begin
        armed = 1'b0;
        fired = 1'b0;
      end
      if (!fired) begin
        if (!armed) begin
          if (mag * 5 >= thr * 3) begin
            if (!dn && gear == 3'd1 && rpm < NEUTRAL_BELOW) neutral_pend = 1'b1;
            armed    = 1'b1;
            deadline = now + HOLD_MS;
          end
        end else if (mag >= thr && past_deadline(now)) begin
          fired = 1'b1;
          if (dn) begin
            gear   = (gear > 3'd1) ? gear - 3'd1 : 3'd1;
            res.ev = EV_DOWN;
          end else begin
            gidx = (gear < 3'd5) ? gear : 5;
            gear = (gear < 3'd6) ? gear + 3'd1 : 3'd6;
            if (neutral_pend) begin
              gear         = 3'd0;
              neutral_pend = 1'b0;
              res.ev       = EV_NEUTRAL;
            end else begin
              res.ev = EV_UP;
              // leaving neutral skips first gear and uses the first gear gain
              if (gidx == 0) begin
                gear = 3'd2;
                gidx = 1;
              end
              if (rpm >= RPM_PTS[0] && rpm <= RPM_PTS[9]) res.cut = cut_time(rpm, ld, gidx);
            end
          end
        end
      end
      res.gear = gear;
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [15:0] item);
      shift_result_t want;
      if (expected_q.size() == 0) begin
        $error("result item with no sample waiting: %h", item);
        fails++;
        return;
      end
      want = expected_q.pop_front();
      if (item[2:0] !== want.gear) begin
        $error("gear: expected %0d, got %0d", want.gear, item[2:0]);
        fails++;
      end
      if (item[4:3] !== want.ev) begin
        $error("event_res: expected %0d, got %0d", want.ev, item[4:3]);
        fails++;
      end
      if (item[14:5] !== want.cut) begin
        $error("cut_ms: expected %0d, got %0d", want.cut, item[14:5]);
        fails++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic [63:0] s_axis_tdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [63:0] cfg_data_i;

  shift_scoreboard sb;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          items_sent;
  int          quiet_cycles;
  logic [31:0] now_t;

  shift_detect_cut_time_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int idle_run(int pct);
    int n;
    n = 0;
    while (n < 20 && $urandom_range(99) < pct) n++;
    return n;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_sample(logic [63:0] item);
    int gap;
    gap = idle_run(send_idle_pct);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= item;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_sample(item);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic lever(int f, int unsigned rpm, int unsigned ld, logic [31:0] now);
    send_sample({2'b00, now, 7'(ld), 14'(rpm), 9'(f)});
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] reg_value(cfg_kind_e kind, logic [2:0] idx);
    logic [63:0] v;
    for (int k = 0; k < 8; k++)
      v[8*k +: 8] = (kind == CFG_LOW) ? 8'($urandom_range(0, 40)) : 8'($urandom_range(0, 255));
    if (kind == CFG_MAX) v = '1;
    if (kind == CFG_MIN) v = '0;
    case (idx)
      REG_CUT_ENABLE:
        v = (kind == CFG_MAX) ? 64'd1 : (kind == CFG_MIN) ? 64'd0 :
            64'($urandom_range(99) < 80);
      REG_BASE_CUT_MS:
        v = (kind == CFG_MAX) ? 64'd254 : (kind == CFG_MIN) ? 64'd0 :
            (kind == CFG_LOW) ? 64'($urandom_range(1, 20)) : 64'($urandom_range(0, 254));
      REG_FORCE_THR: begin
        if (kind == CFG_RANDOM && $urandom_range(99) < 25)
          v[15:0] = {8'($urandom_range(0, 20)), 8'($urandom_range(0, 20))};
        v[63:16] = '0;
      end
      REG_SPEED_GAIN_HI, REG_LOAD_GAIN_HI: v[63:16] = '0;
      REG_GEAR_GAIN: v[63:40] = '0;
      default: ;
    endcase
    return v;
  endfunction

  task automatic apply_config(cfg_kind_e kind);
    foreach (REG_LIST[k]) cfg_write(REG_LIST[k], reg_value(kind, REG_LIST[k]));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int unsigned rand_rpm();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 12) return $urandom_range(0, NEUTRAL_BELOW - 1);
    if (r < 17) return $urandom_range(RPM_PTS[9] + 1, 16383);
    if (r < 22) return RPM_PTS[$urandom_range(0, 9)];
    return $urandom_range(RPM_PTS[0], RPM_PTS[9]);
  endfunction

  function automatic int unsigned rand_load();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return $urandom_range(101, 127);
    if (r < 25) return LOAD_PTS[$urandom_range(0, 9)];
    return $urandom_range(0, 100);
  endfunction

  task automatic push_lever(bit dn, int unsigned mag);
    lever(dn ? -int'(mag) : int'(mag), rand_rpm(), rand_load(), now_t);
  endtask

  // optional release, arm, optional holds before deadline, then full force
  task automatic shift_gesture();
    bit          dn;
    int unsigned thr;
    int unsigned top;
    int unsigned rel_hi;
    int unsigned arm_lo;
    int unsigned hold_lo;
    int unsigned fire_lo;
    int unsigned r;
    logic [31:0] due;
    dn      = ($urandom_range(99) < 35);
    thr     = dn ? sb.thr_pair[15:8] : sb.thr_pair[7:0];
    top     = dn ? 256 : 255;
    rel_hi  = thr * 2 / 5;
    arm_lo  = (thr * 3 + 4) / 5;
    hold_lo = (rel_hi + 1 > 32'(dn)) ? rel_hi + 1 : 32'(dn);
    fire_lo = (thr > 32'(dn)) ? thr : 32'(dn);
    r = $urandom_range(99);
    if (r < 4) now_t = $urandom();
    else if (r < 7) now_t = 32'hFFFF_FFF0 + $urandom_range(0, 15);
    if ($urandom_range(99) < 85) push_lever(dn, $urandom_range(0, rel_hi));
    now_t += $urandom_range(0, 3);
    push_lever(dn, $urandom_range(arm_lo, top));
    due = now_t + HOLD_MS;
    repeat ($urandom_range(0, 2)) begin
      now_t += $urandom_range(0, 32'(due - now_t));
      push_lever(dn, $urandom_range(hold_lo, top));
    end
    r = $urandom_range(99);
    if (r < 8) begin
      now_t = due;
      push_lever(dn, $urandom_range(fire_lo, top));
    end else if (r < 13) begin
      // half the time circle away: not yet past the deadline
      now_t = due + 32'h8000_0000 + $urandom_range(0, 5);
      push_lever(dn, $urandom_range(fire_lo, top));
    end else if (r < 23 && thr > arm_lo) begin
      now_t = due + 32'd1;
      push_lever(dn, $urandom_range(arm_lo, thr - 1));
    end
    if ($urandom_range(99) < 5) now_t = due + $urandom_range(1, 32'h7FFF_FFFF);
    else now_t = due + 32'd1 + $urandom_range(0, 40);
    push_lever(dn, $urandom_range(fire_lo, top));
    if ($urandom_range(99) < 30) begin
      now_t += $urandom_range(0, 3);
      push_lever(dn, $urandom_range(fire_lo, top));
    end
  endtask

  task automatic random_step();
    if ($urandom_range(99) < 12)
      send_sample({$urandom(), $urandom()} & 64'h3FFF_FFFF_FFFF_FFFF);
    else
      shift_gesture();
  endtask

  task automatic run_directed();
    lever(0, 3000, 50, 32'd1000);
    lever(60, 3000, 50, 32'd1000);
    lever(100, 3000, 50, 32'd1010);
    lever(100, 3000, 50, 32'd1011);
    lever(255, 2500, 0, 32'd1012);
    lever(40, 2500, 0, 32'd1013);
    lever(-256, 2500, 0, 32'd1020);
    lever(-256, 8000, 100, 32'd1031);
    lever(-40, 8000, 100, 32'd1032);
    // up arm in first gear at low speed heads for neutral
    lever(60, 1999, 5, 32'd1040);
    lever(100, 16383, 127, 32'd1051);
    lever(0, 0, 0, 32'd1052);
    lever(-60, 0, 0, 32'hFFFF_FFFA);
    lever(-100, 0, 0, 32'd4);
    lever(-100, 0, 0, 32'd5);
    lever(0, 0, 0, 32'd6);
    lever(60, 2000, 100, 32'd10);
    lever(100, 14000, 127, 32'h8000_0014);
    lever(100, 14000, 127, 32'h8000_0013);
    lever(0, 4000, 20, 32'd50);
    lever(99, 5000, 30, 32'd100);
    lever(99, 14001, 30, 32'd200);
    lever(255, 14001, 30, 32'd200);
    lever(-1, 6000, 60, 32'd300);
  endtask

  initial begin
    int target;
    rst_ni          = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tvalid_i = 1'b0;
    m_axis_tready_i = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = REG_CUT_ENABLE;
    cfg_data_i      = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    items_sent      = 0;
    quiet_cycles    = 0;
    now_t           = 32'd500;
    sb = new();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    run_directed();
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      case (p)
        1, 5, 6, 7: apply_config(CFG_RANDOM);
        2: apply_config(CFG_MAX);
        3: apply_config(CFG_MIN);
        4: apply_config(CFG_LOW);
        default: ;
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      target = items_sent + RANDOM_ITEMS / NUM_PHASES;
      while (items_sent < target) random_step();
    end

    drain();
    repeat (100) @(negedge clk_i);
    if (sb.fails == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
src/sdct_pkg.sv
src/sdct_cut.sv
src/shift_detect_cut_time_unit.sv
src/sdct_checker.sv
bench/tb_shift_detect_cut_time_unit.sv
